### rtl/srr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and modular helpers for the Shamir share recovery block.
// No dependencies; imported by every module of the block.
package srr_pkg;

  localparam int MAX_SHARES = 16;
  localparam int WORD_BITS  = 61;
  localparam int IDX_W      = $clog2(MAX_SHARES);
  localparam int CNT_W      = $clog2(MAX_SHARES + 1);
  localparam int STEP_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t MODULUS_RST = word_t'(64'h1FFF_FFFF_FFFF_FFFF);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic {
    OP_DIV,
    OP_MULMOD
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef enum logic {
    AR_IDLE,
    AR_RUN
  } arith_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XI_RD,
    S_XI_DIV,
    S_XJ_CHK,
    S_XJ_DIV,
    S_NUM_MUL,
    S_DEN_MUL,
    S_INV_CHK,
    S_INV_DIV,
    S_INV_MUL,
    S_Y_RD,
    S_Y_DIV,
    S_YN_MUL,
    S_YI_MUL,
    S_DONE
  } seq_state_e;

  // (a + b) mod p for a, b below p.
  function automatic word_t add_mod(word_t a, word_t b, word_t p);
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[WORD_BITS-1:0];
  endfunction

  // (a - b) mod p for a, b below p.
  function automatic word_t sub_mod(word_t a, word_t b, word_t p);
    return (a >= b) ? (a - b) : (a + (p - b));
  endfunction

endpackage

### rtl/srr_share_mem.sv
`timescale 1ns / 1ps
// Share store: x and y memories, one write port and one registered read port.
// Depends on srr_pkg.
module srr_share_mem (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [srr_pkg::IDX_W-1:0] wr_addr_i,
  input  srr_pkg::word_t            wr_x_i,
  input  srr_pkg::word_t            wr_y_i,
  input  logic [srr_pkg::IDX_W-1:0] rd_addr_i,
  output srr_pkg::word_t            rd_x_o,
  output srr_pkg::word_t            rd_y_o
);
  import srr_pkg::*;

  word_t x_mem [MAX_SHARES];
  word_t y_mem [MAX_SHARES];
  word_t rd_x_q;
  word_t rd_y_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      x_mem[wr_addr_i] <= wr_x_i;
      y_mem[wr_addr_i] <= wr_y_i;
    end
    rd_x_q <= x_mem[rd_addr_i];
    rd_y_q <= y_mem[rd_addr_i];
  end

  assign rd_x_o = rd_x_q;
  assign rd_y_o = rd_y_q;

endmodule

### rtl/srr_arith.sv
`timescale 1ns / 1ps
// Shared iterative arithmetic unit: restoring division and shift-add modular multiply,
// one bit per cycle. Depends on srr_pkg.
module srr_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srr_pkg::arith_req_t req_i,
  input  srr_pkg::word_t      a_i,
  input  srr_pkg::word_t      b_i,
  input  srr_pkg::word_t      p_i,
  output logic                done_o,
  output srr_pkg::word_t      quo_o,
  output srr_pkg::word_t      rem_o
);
  import srr_pkg::*;

  arith_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic done_q, done_d;

  arith_op_e op_q;
  word_t a_q, b_q, p_q, quo_q, acc_q;
  logic [WORD_BITS:0] rem_q;

  logic [WORD_BITS:0] rem_sh;
  logic               rem_ge;
  logic               last_step;

  assign rem_sh    = {rem_q[WORD_BITS-1:0], a_q[WORD_BITS-1]};
  assign rem_ge    = rem_sh >= {1'b0, b_q};
  assign last_step = step_q == STEP_W'(WORD_BITS - 1);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    unique case (state_q)
      AR_IDLE: begin
        if (req_i.start) begin
          state_d = AR_RUN;
          step_d  = '0;
        end
      end
      AR_RUN: begin
        step_d = step_q + 1'b1;
        if (last_step) begin
          state_d = AR_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = AR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == AR_IDLE && req_i.start) begin
      op_q  <= req_i.op;
      a_q   <= a_i;
      b_q   <= b_i;
      p_q   <= p_i;
      rem_q <= '0;
      quo_q <= '0;
      acc_q <= '0;
    end else if (state_q == AR_RUN) begin
      if (op_q == OP_DIV) begin
        a_q   <= {a_q[WORD_BITS-2:0], 1'b0};
        rem_q <= rem_ge ? (rem_sh - {1'b0, b_q}) : rem_sh;
        quo_q <= {quo_q[WORD_BITS-2:0], rem_ge};
      end else begin
        // Multiplicand doubles while the multiplier is scanned from its low bit.
        if (b_q[0]) acc_q <= add_mod(acc_q, a_q, p_q);
        a_q <= add_mod(a_q, a_q, p_q);
        b_q <= {1'b0, b_q[WORD_BITS-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = (op_q == OP_DIV) ? rem_q[WORD_BITS-1:0] : acc_q;

endmodule

### rtl/shamir_secret_recovery.sv
`timescale 1ns / 1ps
// Shamir secret recovery top level: share loading, recovery sequencer and result register.
// Depends on srr_pkg, srr_share_mem and srr_arith.
//
// Usage: shares arrive on the input channel (share_x_i, share_y_i, last_share_i) with
// in_valid_i; an item is taken on a clock edge where in_stall_o is low. Shares without the
// last flag are taken one per cycle and written into the share memory. A seventeenth share
// is dropped and marks the set as overflowed. The item with the last flag starts recovery,
// during which in_stall_o stays high.
// Recovery evaluates the Lagrange interpolation at zero over GF(p) with p taken from the
// modulus register, written on the cfg channel; it is to be written only while the block is
// idle, and the block itself does not enforce this. All arithmetic goes through one shared
// unit, and each division or modular multiply holds the sequencer until the unit reports
// done. The result then passes through the done state into the output register. An
// overflowed set or a modulus below two skips the arithmetic and answers from the done state.
// The result (secret_o, status_o) sits in an output register with out_valid_o until taken on
// an edge where out_stall_i is low; a stalled result holds, and the sequencer waits for the
// register to free before returning to idle. Reset empties the store, clears the overflow
// flag and the output valid flag, and sets the modulus to two to the 61 minus one.
module shamir_secret_recovery (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  srr_pkg::word_t cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  srr_pkg::word_t share_x_i,
  input  srr_pkg::word_t share_y_i,
  input  logic           last_share_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output srr_pkg::word_t secret_o,
  output logic [1:0]     status_o
);
  import srr_pkg::*;

  seq_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
  logic ovf_q, ovf_d;
  logic run_q, run_d;
  logic out_valid_q, out_valid_d;
  word_t modulus_q;

  // Working registers of the interpolation.
  word_t xi_q, xi_d, num_q, num_d, den_q, den_d, tmp_q, tmp_d, sum_q, sum_d;
  word_t r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  word_t res_secret_q, res_secret_d;
  logic [1:0] res_status_q, res_status_d;
  word_t secret_q, secret_d;
  logic [1:0] status_q, status_d;

  logic in_accept;
  logic store_full;
  logic [IDX_W-1:0] rd_addr;
  word_t rd_x, rd_y;
  arith_req_t req;
  word_t ar_a, ar_b, ar_quo, ar_rem;
  logic ar_done;
  logic op_go;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != S_IDLE;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign store_full  = count_q == CNT_W'(MAX_SHARES);

  always_comb begin
    unique case (state_q)
      S_XI_RD, S_XI_DIV, S_Y_RD, S_Y_DIV: rd_addr = i_q[IDX_W-1:0];
      default:                            rd_addr = j_q[IDX_W-1:0];
    endcase
  end

  srr_share_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_accept && !store_full),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_x_i    (share_x_i),
    .wr_y_i    (share_y_i),
    .rd_addr_i (rd_addr),
    .rd_x_o    (rd_x),
    .rd_y_o    (rd_y)
  );

  srr_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (ar_a),
    .b_i    (ar_b),
    .p_i    (modulus_q),
    .done_o (ar_done),
    .quo_o  (ar_quo),
    .rem_o  (ar_rem)
  );

  // An arithmetic state issues its request once, then waits for done.
  assign op_go = !run_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    i_d          = i_q;
    j_d          = j_q;
    ovf_d        = ovf_q;
    run_d        = run_q;
    out_valid_d  = out_valid_q && out_stall_i;
    secret_d     = secret_q;
    status_d     = status_q;
    xi_d         = xi_q;
    num_d        = num_q;
    den_d        = den_q;
    tmp_d        = tmp_q;
    sum_d        = sum_q;
    r0_d         = r0_q;
    r1_d         = r1_q;
    t0_d         = t0_q;
    t1_d         = t1_q;
    res_secret_d = res_secret_q;
    res_status_d = res_status_q;
    req.start    = 1'b0;
    req.op       = OP_DIV;
    ar_a         = rd_x;
    ar_b         = modulus_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (store_full) ovf_d = 1'b1;
          else            count_d = count_q + 1'b1;
          if (last_share_i) begin
            i_d   = '0;
            sum_d = '0;
            if (ovf_q || store_full) begin
              res_status_d = ST_OVERFLOW;
              res_secret_d = '0;
              state_d      = S_DONE;
            end else if (modulus_q < word_t'(2)) begin
              res_status_d = ST_OK;
              res_secret_d = '0;
              state_d      = S_DONE;
            end else begin
              state_d = S_XI_RD;
            end
          end
        end
      end

      S_XI_RD: state_d = S_XI_DIV;

      S_XI_DIV: begin
        req.start = op_go;
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          xi_d    = ar_rem;
          num_d   = word_t'(1);
          den_d   = word_t'(1);
          j_d     = '0;
          state_d = S_XJ_CHK;
        end
      end

      S_XJ_CHK: begin
        if (j_q == count_q) begin
          r0_d    = modulus_q;
          r1_d    = den_q;
          t0_d    = '0;
          t1_d    = word_t'(1);
          state_d = S_INV_CHK;
        end else if (j_q == i_q) begin
          j_d = j_q + 1'b1;
        end else begin
          state_d = S_XJ_DIV;
        end
      end

      S_XJ_DIV: begin
        req.start = op_go;
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          tmp_d   = ar_rem;
          state_d = S_NUM_MUL;
        end
      end

      S_NUM_MUL: begin
        req.start = op_go;
        req.op    = OP_MULMOD;
        ar_a      = num_q;
        ar_b      = sub_mod('0, tmp_q, modulus_q);
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          num_d   = ar_rem;
          state_d = S_DEN_MUL;
        end
      end

      S_DEN_MUL: begin
        req.start = op_go;
        req.op    = OP_MULMOD;
        ar_a      = den_q;
        ar_b      = sub_mod(xi_q, tmp_q, modulus_q);
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          den_d   = ar_rem;
          j_d     = j_q + 1'b1;
          state_d = S_XJ_CHK;
        end
      end

      // Extended Euclid: the inverse ends up in t0 when the gcd in r0 is one.
      S_INV_CHK: begin
        if (r1_q == '0) begin
          if (r0_q != word_t'(1)) begin
            res_status_d = ST_ZERO_DEN;
            res_secret_d = '0;
            state_d      = S_DONE;
          end else begin
            state_d = S_Y_RD;
          end
        end else begin
          state_d = S_INV_DIV;
        end
      end

      S_INV_DIV: begin
        req.start = op_go;
        ar_a      = r0_q;
        ar_b      = r1_q;
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          tmp_d   = ar_quo;
          r0_d    = r1_q;
          r1_d    = ar_rem;
          state_d = S_INV_MUL;
        end
      end

      S_INV_MUL: begin
        req.start = op_go;
        req.op    = OP_MULMOD;
        // The quotient never exceeds p; it equals p only when it reduces to zero.
        ar_a      = (tmp_q == modulus_q) ? '0 : tmp_q;
        ar_b      = t1_q;
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          t0_d    = t1_q;
          t1_d    = sub_mod(t0_q, ar_rem, modulus_q);
          state_d = S_INV_CHK;
        end
      end

      S_Y_RD: state_d = S_Y_DIV;

      S_Y_DIV: begin
        req.start = op_go;
        ar_a      = rd_y;
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          tmp_d   = ar_rem;
          state_d = S_YN_MUL;
        end
      end

      S_YN_MUL: begin
        req.start = op_go;
        req.op    = OP_MULMOD;
        ar_a      = tmp_q;
        ar_b      = num_q;
        run_d     = 1'b1;
        if (ar_done) begin
          run_d   = 1'b0;
          tmp_d   = ar_rem;
          state_d = S_YI_MUL;
        end
      end

      S_YI_MUL: begin
        req.start = op_go;
        req.op    = OP_MULMOD;
        ar_a      = tmp_q;
        ar_b      = t0_q;
        run_d     = 1'b1;
        if (ar_done) begin
          run_d = 1'b0;
          sum_d = add_mod(sum_q, ar_rem, modulus_q);
          i_d   = i_q + 1'b1;
          if (i_q + 1'b1 == count_q) begin
            res_status_d = ST_OK;
            res_secret_d = add_mod(sum_q, ar_rem, modulus_q);
            state_d      = S_DONE;
          end else begin
            state_d = S_XI_RD;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          secret_d    = res_secret_q;
          status_d    = res_status_q;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ovf_q       <= 1'b0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      modulus_q   <= MODULUS_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ovf_q       <= ovf_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) modulus_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xi_q         <= xi_d;
    num_q        <= num_d;
    den_q        <= den_d;
    tmp_q        <= tmp_d;
    sum_q        <= sum_d;
    r0_q         <= r0_d;
    r1_q         <= r1_d;
    t0_q         <= t0_d;
    t1_q         <= t1_d;
    res_secret_q <= res_secret_d;
    res_status_q <= res_status_d;
    secret_q     <= secret_d;
    status_q     <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign secret_o    = secret_q;
  assign status_o    = status_q;

endmodule
